[rtl/i2d_pkg.sv]
// i2d_pkg: shared constants, types and a helper function for the integer to
// decimal ASCII converter. No dependencies.
package i2d_pkg;

    localparam int VALUE_W   = 64;
    localparam int DIGITS    = 20;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int CHAR_W    = 8;
    localparam int MAX_CHARS = 20;
    localparam int STEP_W    = $clog2(VALUE_W + 1);
    localparam int DIG_W     = $clog2(DIGITS + 1);
    localparam int EMIT_W    = $clog2(MAX_CHARS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic scan;
        logic emit_minus;
        logic emit_digit;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic top_zero;
        logic negative;
    } status_t;

    // number of double-dabble steps for a width code
    function automatic logic [STEP_W-1:0] width_steps(input logic [1:0] code);
        logic [STEP_W-1:0] n;
        case (code)
            WIDTH_8:  n = STEP_W'(8);
            WIDTH_16: n = STEP_W'(16);
            WIDTH_32: n = STEP_W'(32);
            default:  n = STEP_W'(64);
        endcase
        return n;
    endfunction

endpackage

[rtl/i2d_if.sv]
// i2d_if: valid/ready channel interfaces for the number requests and the
// character results. Depends on i2d_pkg.
interface i2d_in_if;
    import i2d_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [1:0]         width_code;
    logic               is_signed;

    modport source (output valid, output value, output width_code, output is_signed,
                    input ready);
    modport sink   (input valid, input value, input width_code, input is_signed,
                    output ready);
endinterface

interface i2d_out_if;
    import i2d_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

[rtl/i2d_dpath.sv]
// i2d_dpath: magnitude formation, double-dabble BCD register and the output
// character register. Depends on i2d_pkg.
module i2d_dpath (
    input  logic                          clk,
    input  i2d_pkg::cmd_t                 cmd,
    input  logic [i2d_pkg::VALUE_W-1:0]   value,
    input  logic [1:0]                    width_code,
    input  logic                          is_signed,
    output i2d_pkg::status_t              status,
    output logic [i2d_pkg::CHAR_W-1:0]    char_code,
    output logic                          last
);
    import i2d_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic [VALUE_W-1:0] masked;
    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] aligned;
    logic               sign_bit;
    logic [BCD_W-1:0]   bcd_adj;

    always_comb
    begin
        case (width_code)
            WIDTH_8:
            begin
                masked   = {{(VALUE_W-8){1'b0}}, value[7:0]};
                sign_bit = value[7];
            end
            WIDTH_16:
            begin
                masked   = {{(VALUE_W-16){1'b0}}, value[15:0]};
                sign_bit = value[15];
            end
            WIDTH_32:
            begin
                masked   = {{(VALUE_W-32){1'b0}}, value[31:0]};
                sign_bit = value[31];
            end
            default:
            begin
                masked   = value;
                sign_bit = value[VALUE_W-1];
            end
        endcase
    end

    // two's complement within the width; upper bits of a narrow result are
    // discarded by the left alignment below
    assign magnitude = (is_signed && sign_bit) ? (~masked + VALUE_W'(1)) : masked;

    always_comb
    begin
        case (width_code)
            WIDTH_8:  aligned = magnitude << (VALUE_W - 8);
            WIDTH_16: aligned = magnitude << (VALUE_W - 16);
            WIDTH_32: aligned = magnitude << (VALUE_W - 32);
            default:  aligned = magnitude;
        endcase
    end

    // add 3 to each digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                (bcd_reg[4*d +: 4] + 4'd3) : bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            bin_next = aligned;
            bcd_next = '0;
            neg_next = is_signed && sign_bit;
        end
        if (cmd.step)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
        end
        if (cmd.scan)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
        if (cmd.emit_minus)
        begin
            char_next = ASCII_MINUS;
            last_next = cmd.last;
        end
        if (cmd.emit_digit)
        begin
            char_next = ASCII_ZERO + {4'd0, bcd_reg[BCD_W-1 -: 4]};
            last_next = cmd.last;
            bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.top_zero = (bcd_reg[BCD_W-1 -: 4] == 4'd0);
    assign status.negative = neg_reg;
    assign char_code       = char_reg;
    assign last            = last_reg;

endmodule

[rtl/i2d_ctrl.sv]
// i2d_ctrl: sequencer for conversion, leading-zero skip and character
// emission, plus the output valid flag. Depends on i2d_pkg.
module i2d_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           width_code,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  i2d_pkg::status_t     status,
    output i2d_pkg::cmd_t        cmd
);
    import i2d_pkg::*;

    typedef enum logic [1:0] {IDLE, CONV, SCAN, EMIT} state_t;

    localparam logic [EMIT_W-1:0] MAX_CHARS_C = EMIT_W'(MAX_CHARS);
    localparam logic [DIG_W-1:0]  DIGITS_C    = DIG_W'(DIGITS);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [EMIT_W-1:0] emitted_reg, emitted_next;
    logic              minus_reg, minus_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              is_last;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == IDLE);
    assign is_last  = (!minus_reg && dig_reg == DIG_W'(1)) ||
                      (emitted_reg + EMIT_W'(1) == MAX_CHARS_C);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        dig_next       = dig_reg;
        emitted_next   = emitted_reg;
        minus_next     = minus_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = width_steps(width_code);
                    state_next = CONV;
                end
            end
            CONV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    dig_next   = DIGITS_C;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (status.top_zero && dig_reg > DIG_W'(1))
                begin
                    cmd.scan = 1'b1;
                    dig_next = dig_reg - DIG_W'(1);
                end
                else
                begin
                    minus_next   = status.negative;
                    emitted_next = '0;
                    state_next   = EMIT;
                end
            end
            EMIT:
            begin
                if (out_free)
                begin
                    cmd.last       = is_last;
                    out_valid_next = 1'b1;
                    emitted_next   = emitted_reg + EMIT_W'(1);
                    if (minus_reg)
                    begin
                        cmd.emit_minus = 1'b1;
                        minus_next     = 1'b0;
                    end
                    else
                    begin
                        cmd.emit_digit = 1'b1;
                        dig_next       = dig_reg - DIG_W'(1);
                    end
                    if (is_last)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            step_reg      <= '0;
            dig_reg       <= '0;
            emitted_reg   <= '0;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dig_reg       <= dig_next;
            emitted_reg   <= emitted_next;
            minus_reg     <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a character is only written when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_minus || cmd.emit_digit) |-> (!out_valid_reg || out_ready))
        else $error("character written over a pending result");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while converting");

    // the sign only ever leads the text
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_minus |-> (emitted_reg == '0))
        else $error("minus sign not first");

    // digits remain while emitting
    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EMIT) |-> (dig_reg != '0))
        else $error("digit count ran out during emission");

endmodule

[rtl/integer_to_decimal_ascii_top.sv]
// integer_to_decimal_ascii_top: binary integer to decimal ASCII text.
// Depends on i2d_pkg, i2d_if, i2d_ctrl and i2d_dpath.
//
//  channel  modport  payload                           moves
//  number   sink     value[63:0] width_code is_signed  one request per integer
//  text     source   char_code[7:0] last               one character per transfer
//
// Sequence: accept, W double-dabble steps (W = 8, 16, 32 or 64), 20 - D
// leading-zero skips (D = significant digits), entry to emission, then the
// characters one at a time, with a leading '-' when the value is negative.
// Reset (rst_n, asynchronous) clears the sequencer and the output valid flag.
// Text stalls hold emission; number is ready only between requests, and the
// final character may still wait while the next request is taken.
module integer_to_decimal_ascii_top (
    input  logic     clk,
    input  logic     rst_n,
    i2d_in_if.sink   number,
    i2d_out_if.source text
);
    import i2d_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: owns handshakes, step and digit counters
    i2d_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (number.valid),
        .width_code (number.width_code),
        .in_ready   (number.ready),
        .out_ready  (text.ready),
        .out_valid  (text.valid),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: magnitude, BCD shift register, character register
    i2d_dpath u_dpath (
        .clk        (clk),
        .cmd        (cmd),
        .value      (number.value),
        .width_code (number.width_code),
        .is_signed  (number.is_signed),
        .status     (status),
        .char_code  (text.char_code),
        .last       (text.last)
    );

endmodule

[tb/tb_integer_to_decimal_ascii_top.sv]
// tb_integer_to_decimal_ascii_top: self-checking bench for the integer to decimal ASCII
// converter; predicts each character and compares it as it leaves the text channel.
// Depends on i2d_pkg, i2d_if and integer_to_decimal_ascii_top.
module tb_integer_to_decimal_ascii_top;
    import i2d_pkg::*;

    localparam int RANDOM_NUMBERS = 190;  // after the directed set, ~210 in all
    localparam int TAIL_NUMBERS   = 30;   // last stretch runs with no idling
    localparam int DRAIN_CYCLES   = 120;  // idle run-out after the queues empty
    localparam int REPORT_LIMIT   = 10;

    // one number request as driven on the input channel
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         width_code;
        logic               is_signed;
    } number_req_t;

    // one character of decimal text as seen on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n;

    i2d_in_if  number_ch ();
    i2d_out_if text_ch ();

    integer_to_decimal_ascii_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    always #4 clk = ~clk;

    number_req_t pending_numbers[$];  // not yet offered to the block
    text_char_t  expected_text[$];    // characters owed by the block, oldest first
    int          mismatch_count = 0;
    int          src_gap = 0;
    int          sink_gap = 0;

    // Idling stops once only the tail of the stimulus is left.
    function automatic logic idling_allowed();
        return pending_numbers.size() >= TAIL_NUMBERS;
    endfunction

    // Work out the decimal text of one request and queue its characters.
    function automatic void predict_decimal_text(number_req_t req);
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] sign_bit;
        logic [VALUE_W-1:0] mag;
        logic               negative;
        logic [CHAR_W-1:0]  rev_digits[DIGITS];
        logic [CHAR_W-1:0]  chars[DIGITS];
        int                 ndig;
        int                 nchar;
        text_char_t         ch;
        case (req.width_code)
            WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
            WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
            WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
            default:  mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        mag      = req.value & mask;
        sign_bit = (mask >> 1) + 64'd1;
        negative = req.is_signed && ((mag & sign_bit) != '0);
        // two's complement within the width; exact for the most negative value too
        if (negative)
            mag = (~mag + 64'd1) & mask;
        ndig = 0;
        do
        begin
            rev_digits[ndig] = ASCII_ZERO + CHAR_W'(mag % 64'd10);
            mag  = mag / 64'd10;
            ndig = ndig + 1;
        end
        while (mag != '0 && ndig < DIGITS);
        nchar = 0;
        if (negative)
        begin
            chars[0] = ASCII_MINUS;
            nchar    = 1;
        end
        while (ndig > 0 && nchar < DIGITS)
        begin
            ndig         = ndig - 1;
            chars[nchar] = rev_digits[ndig];
            nchar        = nchar + 1;
        end
        // over-long text keeps only its leading characters
        if (nchar > MAX_CHARS)
            nchar = MAX_CHARS;
        for (int i = 0; i < nchar; i++)
        begin
            ch.char_code = chars[i];
            ch.last      = (i == nchar - 1);
            expected_text.push_back(ch);
        end
    endfunction

    task automatic add_number(input logic [VALUE_W-1:0] value, input logic [1:0] width_code,
                              input logic is_signed);
        number_req_t req;
        req.value      = value;
        req.width_code = width_code;
        req.is_signed  = is_signed;
        pending_numbers.push_back(req);
    endtask

    // Request driver: predicts on acceptance, then offers the next number or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_ch.valid      <= 1'b0;
            number_ch.value      <= '0;
            number_ch.width_code <= WIDTH_8;
            number_ch.is_signed  <= 1'b0;
        end
        else if (!number_ch.valid || number_ch.ready)
        begin
            if (number_ch.valid)
                predict_decimal_text({number_ch.value, number_ch.width_code,
                                      number_ch.is_signed});
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                number_ch.valid <= 1'b0;
            end
            else if (pending_numbers.size() > 0)
            begin
                number_req_t req;
                req = pending_numbers.pop_front();
                number_ch.valid      <= 1'b1;
                number_ch.value      <= req.value;
                number_ch.width_code <= req.width_code;
                number_ch.is_signed  <= req.is_signed;
                if (idling_allowed() && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 5);
            end
            else
                number_ch.valid <= 1'b0;
        end
    end

    // Text monitor: checks each accepted character, then stalls in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_ch.ready <= 1'b0;
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                text_char_t want;
                if (expected_text.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected character: char_code=%h last=%b",
                                 text_ch.char_code, text_ch.last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_ch.char_code !== want.char_code || text_ch.last !== want.last)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("text mismatch: char_code exp %h got %h, last exp %b got %b",
                                     want.char_code, text_ch.char_code, want.last,
                                     text_ch.last);
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap = sink_gap - 1;
                text_ch.ready <= 1'b0;
            end
            else
            begin
                text_ch.ready <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 2) == 0)
                    sink_gap = $urandom_range(1, 5);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] wmask;
        logic [1:0]         wc;
        int                 wbits;
        rst_n = 1'b0;

        // directed: zero, extremes of each width, most negative values, stray upper bits
        add_number(64'd0,                  WIDTH_64, 1'b0);
        add_number(64'd0,                  WIDTH_8,  1'b1);
        add_number(64'hFF,                 WIDTH_8,  1'b0);
        add_number(64'h80,                 WIDTH_8,  1'b1);
        add_number(64'h7F,                 WIDTH_8,  1'b1);
        add_number(64'hFFFF,               WIDTH_16, 1'b0);
        add_number(64'h8000,               WIDTH_16, 1'b1);
        add_number(64'hFFFF_FFFF,          WIDTH_32, 1'b0);
        add_number(64'h8000_0000,          WIDTH_32, 1'b1);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, WIDTH_64, 1'b0);  // 20 digits
        add_number(64'h8000_0000_0000_0000, WIDTH_64, 1'b1);  // '-' plus 19 digits
        add_number(64'hFFFF_FFFF_FFFF_FFFF, WIDTH_64, 1'b1);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, WIDTH_64, 1'b1);
        add_number(64'hDEAD_BEEF_CAFE_F00D, WIDTH_8,  1'b0);  // upper bits ignored
        add_number(64'hFFFF_FFFF_FFFF_FF00, WIDTH_8,  1'b1);  // zero under garbage
        add_number(64'h0000_0001_8000_0000, WIDTH_32, 1'b1);
        add_number(64'd9,                  WIDTH_16, 1'b0);
        add_number(64'd10,                 WIDTH_16, 1'b0);
        add_number(64'd10000000000000000000, WIDTH_64, 1'b0);
        add_number(64'd9999999999999999999,  WIDTH_64, 1'b0);

        // random: full-range bits, small magnitudes, digit-count edges, sign-bit edges
        for (int n = 0; n < RANDOM_NUMBERS; n++)
        begin
            wc    = 2'($urandom_range(0, 3));
            wbits = 8 << wc;
            wmask = (wc == WIDTH_64) ? '1 : ((64'd1 << wbits) - 64'd1);
            case ($urandom_range(0, 3))
                0: v = {$urandom, $urandom};
                1:
                begin
                    v = 64'($urandom_range(0, 20));
                    if ($urandom_range(0, 1) == 1)
                        v = -v;
                end
                2:
                begin
                    v = 64'd1;
                    repeat ($urandom_range(0, 19)) v = v * 64'd10;
                    v = v + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default: v = (64'd1 << (wbits - 1)) + 64'($urandom_range(0, 4)) - 64'd2;
            endcase
            if ($urandom_range(0, 1) == 1)
                v = v | ({$urandom, $urandom} & ~wmask);
            add_number(v, wc, 1'($urandom_range(0, 1)));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_numbers.size() > 0 || number_ch.valid || expected_text.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_text.size() > 0)
            $display("%0d expected characters never arrived", expected_text.size());
        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
